@@ hdl/btas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btas_pkg
// Shared types, constants and codes of the box tracking anomaly scorer.
// ----------------------------------------------------------------------------
package btas_pkg;

  localparam int MAX_BOXES  = 16;
  localparam int COORD_BITS = 16;

  localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BOX_W   = 4;   // slot and chosen box field width
  localparam int CNT_W   = 5;   // box count register width
  localparam int SCORE_W = 34;
  localparam int TOTAL_W = 48;
  localparam int GAP_W   = COORD_BITS + 1;
  localparam int SQ_IN_W = 17;
  localparam int LIM_W   = (GAP_W > SQ_IN_W + 1) ? GAP_W : SQ_IN_W + 1;
  localparam int SUM_W   = SCORE_W + 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SCORE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic             cmd;
    logic [BOX_W-1:0] box_slot;
    coord_t           hi_x;
    coord_t           lo_x;
    coord_t           hi_y;
    coord_t           lo_y;
    coord_t           hi_z;
    coord_t           lo_z;
    coord_t           pt_x;
    coord_t           pt_y;
    coord_t           pt_z;
    logic             seq_start;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] point_score;
    logic [BOX_W-1:0]   chosen_box;
    logic               inside_flag;
    logic [TOTAL_W-1:0] seq_total;
  } out_item_t;

  typedef struct packed {
    coord_t hi_x;
    coord_t lo_x;
    coord_t hi_y;
    coord_t lo_y;
    coord_t hi_z;
    coord_t lo_z;
  } box_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    box_t             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [BOX_W-1:0] box;
  } dist_tag_t;

  typedef struct packed {
    logic      vld;
    dist_tag_t tag;
  } dist_req_t;

  typedef struct packed {
    logic               vld;
    dist_tag_t          tag;
    logic [SCORE_W-1:0] sq_dist;
  } dist_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/btas_box_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btas_box_mem
// Box bound store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btas_box_mem (
  input  logic              clk,
  input  btas_pkg::mem_req_t req,
  output btas_pkg::box_t    rd_data
);

  btas_pkg::box_t mem [btas_pkg::MAX_BOXES];
  btas_pkg::box_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/btas_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btas_dist
// Squared outside distance of a point to one box, two stages: gaps and
// squares registered, then the three-way sum with saturation.
// ----------------------------------------------------------------------------
module btas_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  btas_pkg::dist_req_t req,
  input  btas_pkg::box_t      box,
  input  btas_pkg::point_t    pt,
  output btas_pkg::dist_rsp_t rsp
);

  logic [btas_pkg::GAP_W-1:0]      gap [3];
  logic                            big_ax [3];
  logic [2*btas_pkg::SQ_IN_W-1:0]  sq_nxt [3];
  logic [2*btas_pkg::SQ_IN_W-1:0]  sq_r [3];
  logic                            big_r;
  logic                            vld_r;
  btas_pkg::dist_tag_t             tag_r;
  logic [btas_pkg::SUM_W-1:0]      sum;

  function automatic logic [btas_pkg::GAP_W-1:0] axis_gap(
    input btas_pkg::coord_t p,
    input btas_pkg::coord_t hi,
    input btas_pkg::coord_t lo
  );
    logic signed [btas_pkg::GAP_W-1:0] d;
    d = '0;
    // upper bound test wins on an inverted box
    if (p >= hi) begin
      d = btas_pkg::GAP_W'(p) - btas_pkg::GAP_W'(hi);
    end else if (p <= lo) begin
      d = btas_pkg::GAP_W'(lo) - btas_pkg::GAP_W'(p);
    end
    return $unsigned(d);
  endfunction

  always_comb begin
    gap[0] = axis_gap(pt.x, box.hi_x, box.lo_x);
    gap[1] = axis_gap(pt.y, box.hi_y, box.lo_y);
    gap[2] = axis_gap(pt.z, box.hi_z, box.lo_z);
    for (int i = 0; i < 3; i++) begin
      big_ax[i] = btas_pkg::LIM_W'(gap[i]) >=
                  (btas_pkg::LIM_W'(1) << btas_pkg::SQ_IN_W);
      sq_nxt[i] = (2*btas_pkg::SQ_IN_W)'(
                    btas_pkg::LIM_W'(gap[i]) & btas_pkg::LIM_W'({btas_pkg::SQ_IN_W{1'b1}}))
                  * (2*btas_pkg::SQ_IN_W)'(
                    btas_pkg::LIM_W'(gap[i]) & btas_pkg::LIM_W'({btas_pkg::SQ_IN_W{1'b1}}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_nxt[i];
    end
    big_r <= big_ax[0] | big_ax[1] | big_ax[2];
    tag_r <= req.tag;
  end

  always_comb begin
    sum = btas_pkg::SUM_W'(sq_r[0]) + btas_pkg::SUM_W'(sq_r[1])
        + btas_pkg::SUM_W'(sq_r[2]);
    rsp.vld = vld_r;
    rsp.tag = tag_r;
    // saturate a gap too wide to square or a sum beyond the score width
    if (big_r || (sum > btas_pkg::SUM_W'(btas_pkg::SCORE_MAX))) begin
      rsp.sq_dist = btas_pkg::SCORE_MAX;
    end else begin
      rsp.sq_dist = sum[btas_pkg::SCORE_W-1:0];
    end
  end

endmodule

@@ hdl/btas_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btas_ctrl
// Item handshake, read sequencer over the box store, best-box tracking,
// running total and output register.
// ----------------------------------------------------------------------------
module btas_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  btas_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output btas_pkg::out_item_t    out_data,
  input  logic                   cfg_wr_en,
  input  logic [btas_pkg::CNT_W-1:0] cfg_wr_data,
  output btas_pkg::mem_req_t     mem_req,
  output btas_pkg::dist_req_t    dist_req,
  output btas_pkg::point_t       pt,
  input  btas_pkg::dist_rsp_t    dist_rsp
);

  btas_pkg::state_t              state_r, state_nxt;
  logic [btas_pkg::CNT_W-1:0]    box_count_r;
  logic [btas_pkg::CNT_W-1:0]    k_r;
  logic                          seq_r;
  logic [btas_pkg::BOX_W-1:0]    nxt_r;
  logic [btas_pkg::BOX_W-1:0]    idx_r;
  logic [btas_pkg::CNT_W-1:0]    cnt_r;
  btas_pkg::point_t              pt_r;
  logic                          s1_vld_r;
  btas_pkg::dist_tag_t           s1_tag_r;
  logic [btas_pkg::SCORE_W-1:0]  best_d_r;
  logic [btas_pkg::BOX_W-1:0]    best_b_r;
  logic [btas_pkg::BOX_W-1:0]    cur_box_r;
  logic [btas_pkg::TOTAL_W-1:0]  total_r;
  logic                          out_vld_r;
  btas_pkg::out_item_t           out_r;

  logic                          accept;
  logic                          score_acc;
  logic                          rd_en;
  logic                          finish_go;
  logic                          issue_last;
  logic                          take;
  logic [btas_pkg::CNT_W-1:0]    k_eff;
  logic [btas_pkg::BOX_W-1:0]    cur_eff;
  logic [btas_pkg::CNT_W-1:0]    nxt_sum;
  logic [btas_pkg::BOX_W-1:0]    nxt_eff;
  logic [btas_pkg::TOTAL_W:0]    total_sum;
  logic [btas_pkg::TOTAL_W-1:0]  total_nxt;

  assign accept    = in_valid && !in_stall;
  assign score_acc = accept && (in_data.cmd == btas_pkg::CMD_SCORE);

  // effective box count and the current/next pair for a later point
  always_comb begin
    if (box_count_r == '0) begin
      k_eff = btas_pkg::CNT_W'(1);
    end else if (box_count_r > btas_pkg::CNT_W'(btas_pkg::MAX_BOXES)) begin
      k_eff = btas_pkg::CNT_W'(btas_pkg::MAX_BOXES);
    end else begin
      k_eff = box_count_r;
    end
    cur_eff = (btas_pkg::CNT_W'(cur_box_r) >= k_eff) ? '0 : cur_box_r;
    nxt_sum = btas_pkg::CNT_W'(cur_eff) + btas_pkg::CNT_W'(1);
    nxt_eff = (nxt_sum < k_eff) ? nxt_sum[btas_pkg::BOX_W-1:0] : '0;
  end

  assign issue_last = seq_r ? (cnt_r == k_r - btas_pkg::CNT_W'(1))
                            : (cnt_r == btas_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      btas_pkg::ST_IDLE: begin
        if (score_acc) begin
          state_nxt = btas_pkg::ST_ISSUE;
        end
      end
      btas_pkg::ST_ISSUE: begin
        if (issue_last) begin
          state_nxt = btas_pkg::ST_DRAIN;
        end
      end
      btas_pkg::ST_DRAIN: begin
        if (dist_rsp.vld && dist_rsp.tag.last) begin
          state_nxt = btas_pkg::ST_FINISH;
        end
      end
      btas_pkg::ST_FINISH: begin
        if (finish_go) begin
          state_nxt = btas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btas_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    finish_go = 1'b0;
    case (state_r)
      btas_pkg::ST_IDLE:   in_stall  = 1'b0;
      btas_pkg::ST_ISSUE:  rd_en     = 1'b1;
      btas_pkg::ST_DRAIN:  rd_en     = 1'b0;
      btas_pkg::ST_FINISH: finish_go = !out_vld_r || !out_stall;
      default:             in_stall  = 1'b1;
    endcase
  end

  always_comb begin
    mem_req.wr_en   = accept && (in_data.cmd == btas_pkg::CMD_LOAD) &&
                      (btas_pkg::CNT_W'(in_data.box_slot) <
                       btas_pkg::CNT_W'(btas_pkg::MAX_BOXES));
    mem_req.wr_addr = btas_pkg::IDX_W'(in_data.box_slot);
    mem_req.wr_data.hi_x = in_data.hi_x;
    mem_req.wr_data.lo_x = in_data.lo_x;
    mem_req.wr_data.hi_y = in_data.hi_y;
    mem_req.wr_data.lo_y = in_data.lo_y;
    mem_req.wr_data.hi_z = in_data.hi_z;
    mem_req.wr_data.lo_z = in_data.lo_z;
    mem_req.rd_en   = rd_en;
    mem_req.rd_addr = btas_pkg::IDX_W'(idx_r);
  end

  assign dist_req.vld = s1_vld_r;
  assign dist_req.tag = s1_tag_r;
  assign pt           = pt_r;

  // a later point keeps the current box when inside it or strictly nearer
  always_comb begin
    if (dist_rsp.tag.first) begin
      take = 1'b1;
    end else if (seq_r) begin
      take = dist_rsp.sq_dist < best_d_r;
    end else begin
      take = (best_d_r != '0) && (dist_rsp.sq_dist <= best_d_r);
    end
  end

  always_comb begin
    total_sum = {1'b0, total_r} + (btas_pkg::TOTAL_W + 1)'(best_d_r);
    if (seq_r) begin
      total_nxt = btas_pkg::TOTAL_W'(best_d_r);
    end else if (total_sum[btas_pkg::TOTAL_W]) begin
      total_nxt = btas_pkg::TOTAL_MAX;
    end else begin
      total_nxt = total_sum[btas_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btas_pkg::ST_IDLE;
      box_count_r <= btas_pkg::CNT_W'(1);
      cur_box_r   <= '0;
      total_r     <= '0;
      out_vld_r   <= 1'b0;
      s1_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= rd_en;
      if (cfg_wr_en) begin
        box_count_r <= cfg_wr_data;
      end
      if (finish_go) begin
        out_vld_r <= 1'b1;
        cur_box_r <= best_b_r;
        total_r   <= total_nxt;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (score_acc) begin
      k_r     <= k_eff;
      seq_r   <= in_data.seq_start;
      nxt_r   <= nxt_eff;
      idx_r   <= in_data.seq_start ? '0 : cur_eff;
      cnt_r   <= '0;
      pt_r.x  <= in_data.pt_x;
      pt_r.y  <= in_data.pt_y;
      pt_r.z  <= in_data.pt_z;
    end else if (rd_en) begin
      idx_r <= seq_r ? idx_r + btas_pkg::BOX_W'(1) : nxt_r;
      cnt_r <= cnt_r + btas_pkg::CNT_W'(1);
    end
    // tag travels alongside the registered read data
    s1_tag_r.first <= (cnt_r == '0);
    s1_tag_r.last  <= issue_last;
    s1_tag_r.box   <= idx_r;
    if (dist_rsp.vld && take) begin
      best_d_r <= dist_rsp.sq_dist;
      best_b_r <= dist_rsp.tag.box;
    end
    if (finish_go) begin
      out_r.point_score <= best_d_r;
      out_r.chosen_box  <= best_b_r;
      out_r.inside_flag <= (best_d_r == '0);
      out_r.seq_total   <= total_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ hdl/box_tracking_anomaly_scorer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_tracking_anomaly_scorer
// Scores feature points against a store of 3-D boxes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : items with valid/stall. A load item (cmd 0) writes one box's
//            bounds into the box store in the accept cycle; it gives no result.
//            A score item (cmd 1) gives exactly one result item.
//   out_*  : results with valid/stall, held in an output register, so a new
//            item is taken while a finished result still waits.
//   cfg_*  : box_count, written whenever cfg_wr_en is high (while idle).
// Flow: a load item leaves the input free for the next item. A score item reads one box per cycle
//   from the single read port of the box store and runs each box through a
//   two-stage distance unit: a later point reads two boxes, the first point of a
//   sequence reads box_count boxes, and in_stall stays high until the result
//   is in the output register.
// Reset: current box and running total clear to 0, box_count to 1; box
//   bounds are undefined until loaded.
// A stalled result holds; a finished item whose result cannot enter the
//   busy output register waits, and in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module box_tracking_anomaly_scorer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  btas_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output btas_pkg::out_item_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [btas_pkg::CNT_W-1:0]     cfg_wr_data
);

  btas_pkg::mem_req_t  mem_req;
  btas_pkg::box_t      rd_box;
  btas_pkg::dist_req_t dist_req;
  btas_pkg::dist_rsp_t dist_rsp;
  btas_pkg::point_t    pt;

  btas_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_req     (mem_req),
    .dist_req    (dist_req),
    .pt          (pt),
    .dist_rsp    (dist_rsp)
  );

  btas_box_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_box)
  );

  btas_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dist_req),
    .box   (rd_box),
    .pt    (pt),
    .rsp   (dist_rsp)
  );

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("box store read and write in the same cycle");

  a_score_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.cmd == btas_pkg::CMD_SCORE)) |=> in_stall)
    else $error("input taken while a score item is in flight");

  a_inside_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.inside_flag == (out_data.point_score == '0)))
    else $error("inside flag disagrees with point score");

  a_dist_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    dist_req.vld |-> $past(mem_req.rd_en))
    else $error("distance request without a box read");
`endif

endmodule

@@ dv/btas_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btas_checker
// Watches the item and result channels of the box tracking anomaly scorer,
// keeps its own copy of the box bounds, the current box, the sequence total
// and the box count, works out the result of every accepted score item and
// compares each accepted result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module btas_checker
  import btas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               pending_count
);

  // keep the log readable if the block goes badly wrong
  localparam int REPORT_LIMIT = 200;

  box_t               box_store [MAX_BOXES];
  logic [BOX_W-1:0]   cur_box;
  logic [TOTAL_W-1:0] seq_sum;
  logic [CNT_W-1:0]   box_cnt;
  out_item_t          expected_results [$];
  int                 errors = 0;

  function automatic longint gap_sq(coord_t p, coord_t hi, coord_t lo);
    longint g;
    g = 0;
    // the upper test wins on an inverted box
    if (p >= hi) begin
      g = longint'(p) - longint'(hi);
    end else if (p <= lo) begin
      g = longint'(lo) - longint'(p);
    end
    return g * g;
  endfunction

  function automatic logic [SCORE_W-1:0] box_dist(int idx, point_t p);
    longint s;
    box_t   b;
    b = box_store[idx];
    s = gap_sq(p.x, b.hi_x, b.lo_x) + gap_sq(p.y, b.hi_y, b.lo_y)
      + gap_sq(p.z, b.hi_z, b.lo_z);
    return (s > longint'(SCORE_MAX)) ? SCORE_MAX : s[SCORE_W-1:0];
  endfunction

  function automatic out_item_t predict_score(in_item_t it);
    out_item_t          r;
    point_t             p;
    int                 k, cur, nxt, b;
    logic [SCORE_W-1:0] d, best, dc, dn;
    logic [TOTAL_W:0]   t;
    p.x = it.pt_x;
    p.y = it.pt_y;
    p.z = it.pt_z;
    k = (box_cnt == 0) ? 1 : (box_cnt > MAX_BOXES) ? MAX_BOXES : int'(box_cnt);
    if (it.seq_start) begin
      // first point: strictly nearer boxes win, so the lowest index holds ties
      cur  = 0;
      best = box_dist(0, p);
      for (b = 1; b < k; b++) begin
        d = box_dist(b, p);
        if (d < best) begin
          best = d;
          cur  = b;
        end
      end
      seq_sum = TOTAL_W'(best);
    end else begin
      cur = (int'(cur_box) >= k) ? 0 : int'(cur_box);
      nxt = (cur + 1 < k) ? cur + 1 : 0;
      dc  = box_dist(cur, p);
      dn  = box_dist(nxt, p);
      // stay only if inside or strictly nearer; a tie moves on
      if (dc == 0 || dc < dn) begin
        best = dc;
      end else begin
        best = dn;
        cur  = nxt;
      end
      t = seq_sum + best;
      seq_sum = (t > TOTAL_MAX) ? TOTAL_MAX : t[TOTAL_W-1:0];
    end
    cur_box       = cur[BOX_W-1:0];
    r.point_score = best;
    r.chosen_box  = cur[BOX_W-1:0];
    r.inside_flag = (best == 0);
    r.seq_total   = seq_sum;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      cur_box = '0;
      seq_sum = '0;
      box_cnt = CNT_W'(1);
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        box_cnt = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_LOAD) begin
          box_store[in_data.box_slot] = {in_data.hi_x, in_data.lo_x, in_data.hi_y,
                                         in_data.lo_y, in_data.hi_z, in_data.lo_z};
        end else begin
          expected_results = {expected_results, predict_score(in_data)};
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t ns: result item with nothing expected: score %0d box %0d",
                     $time, out_data.point_score, out_data.chosen_box);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("point_score", 64'(want.point_score), 64'(out_data.point_score));
          check_field("chosen_box", 64'(want.chosen_box), 64'(out_data.chosen_box));
          check_field("inside_flag", 64'(want.inside_flag), 64'(out_data.inside_flag));
          check_field("seq_total", 64'(want.seq_total), 64'(out_data.seq_total));
        end
      end
    end
    pending_count <= expected_results.size();
    fail_count    <= errors;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the box tracking anomaly scorer with a directed opening (bound
// extremes, inverted and all-covering boxes, ties and a count of zero) and
// then random phases of loads and point sequences under several box counts,
// some above range, with random gaps on the sender and random stalls on
// the result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import btas_pkg::*;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  int               fail_count;
  int               pending_count;

  box_t             shadow_box [MAX_BOXES];
  logic [CNT_W-1:0] count_now   = 1;
  bit               idle_on     = 1'b0;
  int               stall_mode  = 0;
  int               stall_left  = 0;
  bit               stall_now   = 1'b0;

  box_tracking_anomaly_scorer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  btas_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: runs of stall and no stall, mostly short, now and then long
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if (stall_mode == 0) begin
        stall_now  = 1'b0;
        stall_left = $urandom_range(1, 8);
      end else begin
        stall_now  = ($urandom_range(0, 99) < ((stall_mode == 2) ? 50 : 25));
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
      end
    end
    stall_left = stall_left - 1;
    out_stall <= stall_now;
  end

  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int eff_count();
    return (count_now == 0) ? 1 : (count_now > MAX_BOXES) ? MAX_BOXES : int'(count_now);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic coord_t near_axis(coord_t a, coord_t b);
    int l, h;
    l = (a < b) ? a : b;
    h = (a < b) ? b : a;
    return clamp_coord(l - 768 + int'($urandom_range(0, h - l + 1536)));
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic box_t rand_box();
    coord_t hi [3];
    coord_t lo [3];
    int     sel, c, r, a;
    sel = $urandom_range(0, 19);
    for (a = 0; a < 3; a++) begin
      if (sel < 15) begin
        c = int'($urandom_range(0, 40000)) - 20000;
        r = $urandom_range(0, 3000);
        hi[a] = clamp_coord(c + r);
        lo[a] = clamp_coord(c - r);
      end else if (sel < 18) begin
        // free bounds, often inverted
        hi[a] = coord_t'($urandom);
        lo[a] = coord_t'($urandom);
      end else if (sel == 18) begin
        hi[a] = 16'sh7fff;
        lo[a] = 16'sh8000;
      end else begin
        hi[a] = coord_t'($urandom);
        lo[a] = hi[a];
      end
    end
    return '{hi[0], lo[0], hi[1], lo[1], hi[2], lo[2]};
  endfunction

  function automatic point_t rand_point();
    point_t p;
    box_t   b;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      b   = shadow_box[$urandom_range(0, eff_count() - 1)];
      p.x = near_axis(b.hi_x, b.lo_x);
      p.y = near_axis(b.hi_y, b.lo_y);
      p.z = near_axis(b.hi_z, b.lo_z);
    end else if (sel < 85) begin
      p.x = coord_t'($urandom);
      p.y = coord_t'($urandom);
      p.z = coord_t'($urandom);
    end else begin
      p.x = corner_coord();
      p.y = corner_coord();
      p.z = corner_coord();
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // leave valid high after the accept unless a gap follows
  task automatic send(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_box(input logic [BOX_W-1:0] slot, input box_t b);
    in_item_t it;
    it.cmd      = CMD_LOAD;
    it.box_slot = slot;
    {it.hi_x, it.lo_x, it.hi_y, it.lo_y, it.hi_z, it.lo_z} = b;
    it.pt_x      = coord_t'($urandom);
    it.pt_y      = coord_t'($urandom);
    it.pt_z      = coord_t'($urandom);
    it.seq_start = 1'($urandom);
    shadow_box[slot] = b;
    send(it);
  endtask

  task automatic score_point(input point_t p, input logic first);
    in_item_t it;
    it.cmd      = CMD_SCORE;
    it.box_slot = BOX_W'($urandom);
    {it.hi_x, it.lo_x, it.hi_y, it.lo_y, it.hi_z, it.lo_z} = {$urandom, $urandom, $urandom};
    it.pt_x      = p.x;
    it.pt_y      = p.y;
    it.pt_z      = p.z;
    it.seq_start = first;
    send(it);
  endtask

  // only while idle: drain all results, then let any trailing load settle
  task automatic set_box_count(input logic [CNT_W-1:0] v);
    while (pending_count != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_now = v;
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0] counts [10];
    int               ph, n, s;

    counts = '{16, 0, 17, 1, 31, 5, 2, 16, 9, 3};
    counts[5] = CNT_W'($urandom_range(2, 15));
    counts[8] = CNT_W'($urandom_range(2, 15));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening, one box in use after reset
    load_box(0, '{2560, 0, 2560, 0, 2560, 0});
    score_point('{5120, 0, 0}, 1'b0);            // later point with no sequence yet
    score_point('{256, 256, 256}, 1'b1);
    score_point('{32767, 32767, 32767}, 1'b0);
    score_point('{-32768, -32768, -32768}, 1'b0);
    load_box(1, '{10240, 7680, 2560, 0, 2560, 0});
    load_box(2, '{-2560, 2560, -2560, 2560, -2560, 2560});   // inverted
    load_box(3, '{32767, -32768, 32767, -32768, 32767, -32768});
    in_valid <= 1'b0;
    set_box_count(4);
    score_point('{5120, 0, 0}, 1'b1);            // only the widest box holds it
    score_point('{5120, 0, 0}, 1'b0);            // next box wraps from the last box to box 0
    score_point('{1280, 1280, 1280}, 1'b1);      // first containing box wins
    score_point('{5120, 1280, 1280}, 1'b0);      // equal distance: move on
    score_point('{1280, 1280, 1280}, 1'b0);
    score_point('{2560, 2560, 2560}, 1'b0);
    score_point('{0, -32768, 32767}, 1'b0);
    score_point('{-32768, -32768, -32768}, 1'b0);
    in_valid <= 1'b0;
    set_box_count(0);
    score_point('{1280, 0, 0}, 1'b0);            // current box beyond the count
    score_point('{-1, -1, -1}, 1'b1);

    // fill every slot before any wider count is used
    for (s = 0; s < MAX_BOXES; s++) begin
      load_box(s[BOX_W-1:0], rand_box());
    end

    for (ph = 0; ph < 10; ph++) begin
      in_valid <= 1'b0;
      set_box_count(counts[ph]);
      idle_on    = (ph % 4 != 3);
      stall_mode = ph % 3;
      // carry the sequence over the count change
      score_point(rand_point(), 1'b0);
      for (n = 1; n < 120; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          load_box(BOX_W'($urandom_range(0, MAX_BOXES - 1)), rand_box());
        end else begin
          score_point(rand_point(), $urandom_range(0, 9) == 0);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
